>>> rtl/gtp_pkg.sv
package gtp_pkg;

  // Field widths
  localparam int unsigned POS_W    = 24;
  localparam int unsigned DIFF_W   = 25;
  localparam int unsigned YAW_W    = 16;
  localparam int unsigned TOL_D_W  = 20;
  localparam int unsigned TOL_Y_W  = 15;
  localparam int unsigned GAIN_W   = 10;
  localparam int unsigned SPEED_W  = 16;
  localparam int unsigned RATE_W   = 18;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned DIST_W   = 24;
  localparam int unsigned CFG_W    = 24;
  localparam int unsigned IDX_W    = 3;

  // CORDIC datapath widths
  localparam int unsigned VEC_W    = 36;
  localparam int unsigned ANG_W    = 34;
  localparam int unsigned ATAN_W   = 30;
  localparam int unsigned BEAR_W   = 17;
  localparam int unsigned ERR_W    = 18;
  localparam int unsigned GUARD_BITS = 8;
  localparam int unsigned MAX_STEPS  = 32;
  localparam int unsigned CORDIC_STEPS_DEF = 16;

  // Shared multiplier and distance scaling
  localparam int unsigned MUL_A_W  = 25;
  localparam int unsigned MUL_B_W  = 19;
  localparam int unsigned PROD_W   = 44;
  localparam int unsigned ACC_W    = 60;
  localparam int unsigned SPLIT_W  = 18;

  localparam logic signed [ANG_W-1:0]  PI_Q30       = 34'sd3373259426;
  localparam logic signed [ERR_W-1:0]  PI_Q13       = 18'sd25736;
  localparam logic signed [ERR_W-1:0]  TWO_PI_Q13   = 18'sd51472;
  localparam logic [TOL_Y_W-1:0]       HALF_PI_Q13  = 15'd12868;
  localparam logic [DIST_W-1:0]        INV_GAIN_Q24 = 24'd10188014;
  localparam logic signed [35:0]       RATE_MAX     = 36'sd131071;
  localparam logic signed [35:0]       RATE_MIN     = -36'sd131072;

  // Register indexes on the configuration port
  typedef enum logic [IDX_W-1:0] {
    REG_TARGET_X         = 3'd0,
    REG_TARGET_Y         = 3'd1,
    REG_DIST_TOLERANCE   = 3'd2,
    REG_YAW_TOLERANCE    = 3'd3,
    REG_TURN_GAIN_MOVING = 3'd4,
    REG_TURN_GAIN_FINAL  = 3'd5,
    REG_LINEAR_GAIN      = 3'd6,
    REG_MAX_FWD_SPEED    = 3'd7
  } reg_idx_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_IDLE      = 3'd0,
    STAT_FIX_YAW   = 3'd1,
    STAT_GO        = 3'd2,
    STAT_SUCCEEDED = 3'd3,
    STAT_CANCELED  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_ACTIVE    = 2'd1,
    PH_SUCCEEDED = 2'd2,
    PH_CANCELED  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    CMD_NONE       = 2'd0,
    CMD_TURN_MOVE  = 2'd1,
    CMD_TURN_FINAL = 2'd2,
    CMD_DRIVE      = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'd0,
    S_DIFF = 4'd1,
    S_PRE  = 4'd2,
    S_ROT  = 4'd3,
    S_MLO  = 4'd4,
    S_MHI  = 4'd5,
    S_DIST = 4'd6,
    S_DEC  = 4'd7,
    S_CMD  = 4'd8,
    S_FIN  = 4'd9
  } state_t;

  // atan(2^-i) in Q.30 rad, truncated
  function automatic logic [ATAN_W-1:0] atan_q30(input logic [4:0] idx);
    logic [ATAN_W-1:0] r;
    unique case (idx)
      5'd0:  r = 30'd843314856;
      5'd1:  r = 30'd497837829;
      5'd2:  r = 30'd263043836;
      5'd3:  r = 30'd133525158;
      5'd4:  r = 30'd67021686;
      5'd5:  r = 30'd33543515;
      5'd6:  r = 30'd16775850;
      5'd7:  r = 30'd8388437;
      5'd8:  r = 30'd4194282;
      5'd9:  r = 30'd2097149;
      5'd10: r = 30'd1048575;
      5'd11: r = 30'd524287;
      5'd12: r = 30'd262143;
      5'd13: r = 30'd131071;
      5'd14: r = 30'd65535;
      5'd15: r = 30'd32767;
      5'd16: r = 30'd16383;
      5'd17: r = 30'd8191;
      5'd18: r = 30'd4095;
      5'd19: r = 30'd2047;
      5'd20: r = 30'd1023;
      5'd21: r = 30'd511;
      5'd22: r = 30'd255;
      5'd23: r = 30'd127;
      5'd24: r = 30'd63;
      5'd25: r = 30'd31;
      5'd26: r = 30'd15;
      5'd27: r = 30'd8;
      5'd28: r = 30'd4;
      5'd29: r = 30'd2;
      5'd30: r = 30'd1;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/go_to_point_steering_controller_core.sv
// One request at a time: in_ready is low while a request is in work, and a finished
// result waits in S_FIN until the output register is free. The vectoring CORDIC does
//   one rotation per cycle on a shared shifter/adder, and one 25x19 multiplier serves
//   distance and commands.
// A finished result sits in the output register while the next request is taken.
// Reset (rst_n low, synchronous): no goal active, configuration registers to defaults, output empty.
module go_to_point_steering_controller_core #(
  parameter int unsigned CORDIC_STEPS = gtp_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // configuration
  input  logic                                  cfg_wr_en,
  input  logic [gtp_pkg::IDX_W-1:0]             cfg_index,
  input  logic [gtp_pkg::CFG_W-1:0]             cfg_wr_data,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [gtp_pkg::POS_W-1:0]      in_current_x,
  input  logic signed [gtp_pkg::POS_W-1:0]      in_current_y,
  input  logic signed [gtp_pkg::YAW_W-1:0]      in_current_yaw,
  input  logic                                  in_cancel_request,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [gtp_pkg::SPEED_W-1:0]           out_fwd_speed,
  output logic signed [gtp_pkg::RATE_W-1:0]     out_angular_rate,
  output logic [gtp_pkg::STATUS_W-1:0]          out_status,
  output logic [gtp_pkg::DIST_W-1:0]            out_distance_error,
  output logic signed [gtp_pkg::YAW_W-1:0]      out_heading_error,
  output logic                                  out_large_heading_error
);
  import gtp_pkg::*;

  localparam int unsigned ROT_N = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
  localparam logic [4:0]  ROT_LAST = 5'(ROT_N - 1);

  // Control state
  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic [4:0] cnt_r, cnt_nxt;

  // Configuration registers
  logic signed [POS_W-1:0] target_x_r, target_y_r;
  logic [TOL_D_W-1:0]      dist_tol_r;
  logic [TOL_Y_W-1:0]      yaw_tol_r;
  logic [GAIN_W-1:0]       gain_move_r, gain_final_r, lin_gain_r;
  logic [SPEED_W-1:0]      max_speed_r;

  // Datapath registers
  logic signed [POS_W-1:0]  cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic signed [YAW_W-1:0]  yaw_r, yaw_nxt;
  logic                     cancel_r, cancel_nxt;
  logic signed [DIFF_W-1:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic                     zero_r, zero_nxt;
  logic signed [VEC_W-1:0]  vx_r, vx_nxt, vy_r, vy_nxt;
  logic signed [ANG_W-1:0]  z_r, z_nxt;
  logic signed [BEAR_W-1:0] bear_r, bear_nxt;
  logic signed [YAW_W-1:0]  err_r, err_nxt;
  logic [TOL_Y_W-1:0]       aerr_r, aerr_nxt;
  logic                     large_r, large_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic [ACC_W-1:0]         acc_r, acc_nxt;
  logic [DIST_W-1:0]        dist_r, dist_nxt;
  cmd_t                     cmd_r, cmd_nxt;
  status_t                  stat_r, stat_nxt;

  // Output register
  logic [SPEED_W-1:0]        o_lin_r, o_lin_nxt;
  logic signed [RATE_W-1:0]  o_ang_r, o_ang_nxt;
  status_t                   o_stat_r, o_stat_nxt;
  logic [DIST_W-1:0]         o_dist_r, o_dist_nxt;
  logic signed [YAW_W-1:0]   o_err_r, o_err_nxt;
  logic                      o_large_r, o_large_nxt;

  // Shared multiplier
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic                      mul_en;

  // Combinational helpers
  logic signed [VEC_W-1:0]  dx_ext, dy_ext, sx, sy;
  logic signed [ANG_W-1:0]  atan_ext, z_rnd;
  logic signed [ERR_W-1:0]  err_raw, err_wrap;
  logic signed [YAW_W-1:0]  err_neg;
  logic [ACC_W-1:0]         dist_sum;
  logic                     far, misaligned, out_free;
  logic signed [PROD_W-1:0] rnd;
  logic [25:0]              lin_full;
  logic signed [35:0]       ang_full;
  logic [SPEED_W-1:0]       lin_cmd;
  logic signed [RATE_W-1:0] ang_cmd;

  assign mul_p = mul_a * mul_b;

  assign in_ready                = (state_r == S_IDLE);
  assign out_valid               = out_valid_r;
  assign out_fwd_speed           = o_lin_r;
  assign out_angular_rate        = o_ang_r;
  assign out_status              = o_stat_r;
  assign out_distance_error      = o_dist_r;
  assign out_heading_error       = o_err_r;
  assign out_large_heading_error = o_large_r;

  // Pre-rotation inputs, shift unit and atan term
  assign dx_ext   = VEC_W'(dx_r);
  assign dy_ext   = VEC_W'(dy_r);
  assign sx       = vx_r >>> cnt_r;
  assign sy       = vy_r >>> cnt_r;
  assign atan_ext = ANG_W'(atan_q30(cnt_r));
  assign z_rnd    = z_r + ANG_W'(65536);

  // Heading error and its wrap into (-pi, pi]
  always_comb begin
    err_raw = ERR_W'(bear_r) - ERR_W'(yaw_r);
    priority if (err_raw > PI_Q13) begin
      err_wrap = err_raw - TWO_PI_Q13;
    end else if (err_raw <= -PI_Q13) begin
      err_wrap = err_raw + TWO_PI_Q13;
    end else begin
      err_wrap = err_raw;
    end
  end

  assign err_neg    = -err_r;
  assign dist_sum   = acc_r + {prod_r[41:0], 18'b0};
  assign far        = dist_r > DIST_W'(dist_tol_r);
  assign misaligned = aerr_r > yaw_tol_r;
  assign out_free   = !out_valid_r || out_ready;

  // Round and saturate the commands from the product
  always_comb begin
    rnd      = prod_r + PROD_W'(128);
    lin_full = rnd[33:8];
    ang_full = rnd[43:8];
    lin_cmd  = (lin_full > 26'(max_speed_r)) ? max_speed_r : lin_full[SPEED_W-1:0];
    priority if (ang_full > RATE_MAX) begin
      ang_cmd = RATE_MAX[RATE_W-1:0];
    end else if (ang_full < RATE_MIN) begin
      ang_cmd = RATE_MIN[RATE_W-1:0];
    end else begin
      ang_cmd = ang_full[RATE_W-1:0];
    end
  end

  // Sequencer: next state and datapath
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r;
    cnt_nxt       = cnt_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    yaw_nxt       = yaw_r;
    cancel_nxt    = cancel_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    zero_nxt      = zero_r;
    vx_nxt        = vx_r;
    vy_nxt        = vy_r;
    z_nxt         = z_r;
    bear_nxt      = bear_r;
    err_nxt       = err_r;
    aerr_nxt      = aerr_r;
    large_nxt     = large_r;
    acc_nxt       = acc_r;
    dist_nxt      = dist_r;
    cmd_nxt       = cmd_r;
    stat_nxt      = stat_r;
    o_lin_nxt     = o_lin_r;
    o_ang_nxt     = o_ang_r;
    o_stat_nxt    = o_stat_r;
    o_dist_nxt    = o_dist_r;
    o_err_nxt     = o_err_r;
    o_large_nxt   = o_large_r;
    mul_en        = 1'b0;
    mul_a         = '0;
    mul_b         = '0;

    // drop the result once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cur_x_nxt  = in_current_x;
          cur_y_nxt  = in_current_y;
          yaw_nxt    = in_current_yaw;
          cancel_nxt = in_cancel_request;
          state_nxt  = S_DIFF;
        end
      end
      S_DIFF: begin
        dx_nxt    = DIFF_W'(target_x_r) - DIFF_W'(cur_x_r);
        dy_nxt    = DIFF_W'(target_y_r) - DIFF_W'(cur_y_r);
        state_nxt = S_PRE;
      end
      S_PRE: begin
        // rotate into the right half plane, add guard bits
        zero_nxt = (dx_r == '0) && (dy_r == '0);
        if (dx_r[DIFF_W-1]) begin
          vx_nxt = (-dx_ext) <<< GUARD_BITS;
          vy_nxt = (-dy_ext) <<< GUARD_BITS;
          z_nxt  = dy_r[DIFF_W-1] ? -PI_Q30 : PI_Q30;
        end else begin
          vx_nxt = dx_ext <<< GUARD_BITS;
          vy_nxt = dy_ext <<< GUARD_BITS;
          z_nxt  = '0;
        end
        cnt_nxt   = '0;
        state_nxt = S_ROT;
      end
      S_ROT: begin
        // one vectoring rotation per cycle
        if (!vy_r[VEC_W-1]) begin
          vx_nxt = vx_r + sy;
          vy_nxt = vy_r - sx;
          z_nxt  = z_r + atan_ext;
        end else begin
          vx_nxt = vx_r - sy;
          vy_nxt = vy_r + sx;
          z_nxt  = z_r - atan_ext;
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == ROT_LAST) begin
          state_nxt = S_MLO;
        end
      end
      S_MLO: begin
        // low half of magnitude times 1/K; round the bearing to Q3.13
        mul_en    = 1'b1;
        mul_a     = MUL_A_W'(INV_GAIN_Q24);
        mul_b     = MUL_B_W'(vx_r[SPLIT_W-1:0]);
        bear_nxt  = zero_r ? '0 : z_rnd[ANG_W-1:17];
        state_nxt = S_MHI;
      end
      S_MHI: begin
        mul_en    = 1'b1;
        mul_a     = MUL_A_W'(INV_GAIN_Q24);
        mul_b     = MUL_B_W'(vx_r[2*SPLIT_W-1:SPLIT_W]);
        acc_nxt   = ACC_W'(prod_r) + (ACC_W'(1) << 31);
        err_nxt   = err_wrap[YAW_W-1:0];
        state_nxt = S_DIST;
      end
      S_DIST: begin
        dist_nxt  = (dist_sum[ACC_W-1:56] != '0) ? '1 : dist_sum[55:32];
        aerr_nxt  = err_r[YAW_W-1] ? err_neg[TOL_Y_W-1:0] : err_r[TOL_Y_W-1:0];
        state_nxt = S_DEC;
      end
      S_DEC: begin
        large_nxt = aerr_r > HALF_PI_Q13;
        cmd_nxt   = CMD_NONE;
        unique case (phase_r)
          PH_ACTIVE: begin
            priority if (far && cancel_r) begin
              phase_nxt = PH_CANCELED;
              stat_nxt  = STAT_CANCELED;
            end else if (far && misaligned) begin
              cmd_nxt  = CMD_TURN_MOVE;
              stat_nxt = STAT_FIX_YAW;
            end else if (far) begin
              cmd_nxt  = CMD_DRIVE;
              stat_nxt = STAT_GO;
            end else if (misaligned) begin
              cmd_nxt  = CMD_TURN_FINAL;
              stat_nxt = STAT_FIX_YAW;
            end else begin
              phase_nxt = PH_SUCCEEDED;
              stat_nxt  = STAT_SUCCEEDED;
            end
          end
          PH_SUCCEEDED: stat_nxt = STAT_SUCCEEDED;
          PH_CANCELED:  stat_nxt = STAT_CANCELED;
          PH_IDLE:      stat_nxt = STAT_IDLE;
        endcase
        state_nxt = S_CMD;
      end
      S_CMD: begin
        // gain times error or distance
        mul_en = 1'b1;
        unique case (cmd_r)
          CMD_TURN_MOVE: begin
            mul_a = MUL_A_W'(err_r);
            mul_b = MUL_B_W'(gain_move_r);
          end
          CMD_TURN_FINAL: begin
            mul_a = MUL_A_W'(err_r);
            mul_b = MUL_B_W'(gain_final_r);
          end
          CMD_DRIVE: begin
            mul_a = MUL_A_W'(dist_r);
            mul_b = MUL_B_W'(lin_gain_r);
          end
          CMD_NONE: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_lin_nxt     = (cmd_r == CMD_DRIVE) ? lin_cmd : '0;
          o_ang_nxt     = ((cmd_r == CMD_TURN_MOVE) || (cmd_r == CMD_TURN_FINAL)) ?
                          ang_cmd : '0;
          o_stat_nxt    = stat_r;
          o_dist_nxt    = dist_r;
          o_err_nxt     = err_r;
          o_large_nxt   = large_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // a target write starts a new goal
    if (cfg_wr_en && ((reg_idx_t'(cfg_index) == REG_TARGET_X) ||
                      (reg_idx_t'(cfg_index) == REG_TARGET_Y))) begin
      phase_nxt = PH_ACTIVE;
    end
  end

  assign prod_nxt = mul_en ? mul_p : prod_r;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_x_r   <= '0;
      target_y_r   <= '0;
      dist_tol_r   <= 20'd102;
      yaw_tol_r    <= 15'd1638;
      gain_move_r  <= 10'd128;
      gain_final_r <= 10'd179;
      lin_gain_r   <= 10'd128;
      max_speed_r  <= 16'd819;
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_index))
        REG_TARGET_X:         target_x_r   <= cfg_wr_data[POS_W-1:0];
        REG_TARGET_Y:         target_y_r   <= cfg_wr_data[POS_W-1:0];
        REG_DIST_TOLERANCE:   dist_tol_r   <= cfg_wr_data[TOL_D_W-1:0];
        REG_YAW_TOLERANCE:    yaw_tol_r    <= cfg_wr_data[TOL_Y_W-1:0];
        REG_TURN_GAIN_MOVING: gain_move_r  <= cfg_wr_data[GAIN_W-1:0];
        REG_TURN_GAIN_FINAL:  gain_final_r <= cfg_wr_data[GAIN_W-1:0];
        REG_LINEAR_GAIN:      lin_gain_r   <= cfg_wr_data[GAIN_W-1:0];
        REG_MAX_FWD_SPEED:    max_speed_r  <= cfg_wr_data[SPEED_W-1:0];
      endcase
    end
  end

  // Datapath and output payload
  always_ff @(posedge clk) begin
    cnt_r     <= cnt_nxt;
    cur_x_r   <= cur_x_nxt;
    cur_y_r   <= cur_y_nxt;
    yaw_r     <= yaw_nxt;
    cancel_r  <= cancel_nxt;
    dx_r      <= dx_nxt;
    dy_r      <= dy_nxt;
    zero_r    <= zero_nxt;
    vx_r      <= vx_nxt;
    vy_r      <= vy_nxt;
    z_r       <= z_nxt;
    bear_r    <= bear_nxt;
    err_r     <= err_nxt;
    aerr_r    <= aerr_nxt;
    large_r   <= large_nxt;
    prod_r    <= prod_nxt;
    acc_r     <= acc_nxt;
    dist_r    <= dist_nxt;
    cmd_r     <= cmd_nxt;
    stat_r    <= stat_nxt;
    o_lin_r   <= o_lin_nxt;
    o_ang_r   <= o_ang_nxt;
    o_stat_r  <= o_stat_nxt;
    o_dist_r  <= o_dist_nxt;
    o_err_r   <= o_err_nxt;
    o_large_r <= o_large_nxt;
  end

endmodule

>>> sim/steer_check.sv
module steer_check #(
  parameter int unsigned STEPS = gtp_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [gtp_pkg::IDX_W-1:0]         cfg_index,
  input  logic [gtp_pkg::CFG_W-1:0]         cfg_wr_data,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic signed [gtp_pkg::POS_W-1:0]  in_current_x,
  input  logic signed [gtp_pkg::POS_W-1:0]  in_current_y,
  input  logic signed [gtp_pkg::YAW_W-1:0]  in_current_yaw,
  input  logic                              in_cancel_request,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [gtp_pkg::SPEED_W-1:0]       out_fwd_speed,
  input  logic signed [gtp_pkg::RATE_W-1:0] out_angular_rate,
  input  logic [gtp_pkg::STATUS_W-1:0]      out_status,
  input  logic [gtp_pkg::DIST_W-1:0]        out_distance_error,
  input  logic signed [gtp_pkg::YAW_W-1:0]  out_heading_error,
  input  logic                              out_large_heading_error,
  output int                                mismatches,
  output int                                pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import gtp_pkg::*;

  localparam int unsigned ROT_STEPS = (STEPS > 32) ? 32 : STEPS;
  localparam longint PI_Q30L    = 64'sd3373259426;
  localparam longint PI_Q13L    = 64'sd25736;
  localparam longint HALF_PI_L  = 64'sd12868;
  localparam longint INV_K_Q24  = 64'sd10188014;
  localparam longint DIST_CAP   = 64'sd16777215;
  localparam longint RATE_HI    = 64'sd131071;
  localparam longint RATE_LO    = -64'sd131072;

  typedef struct packed {
    logic [SPEED_W-1:0]        speed;
    logic signed [RATE_W-1:0]  rate;
    status_t                   status;
    logic [DIST_W-1:0]         dist_err;
    logic signed [YAW_W-1:0]   heading;
    logic                      wide_err;
  } steer_cmd_t;

  // arctan(2^-i) in Q.30 radians, truncated
  longint atan_lut [32] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
    65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31,
    15, 8, 4, 2, 1, 0};

  // shadow of the register file and the goal phase
  logic signed [POS_W-1:0] goal_x, goal_y;
  logic [TOL_D_W-1:0]      near_tol;
  logic [TOL_Y_W-1:0]      align_tol;
  logic [GAIN_W-1:0]       k_turn_move, k_turn_final, k_lin;
  logic [SPEED_W-1:0]      speed_cap;
  phase_t                  goal_phase;

  steer_cmd_t expected_q[$];
  steer_cmd_t head;
  int fail_count = 0;
  int pend_count = 0;

  assign mismatches = fail_count;
  assign pending    = pend_count;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    fail_count++;
    $display("%0t: %s mismatch: got %0d, want %0d", $time, what, got, want);
  endtask

  function automatic longint turn_rate(input logic [GAIN_W-1:0] gain, input longint err);
    longint t;
    t = (longint'(gain) * err + 128) >>> 8;
    if (t > RATE_HI) t = RATE_HI;
    if (t < RATE_LO) t = RATE_LO;
    return t;
  endfunction

  // Compute the command for one request and advance the goal phase
  function automatic steer_cmd_t predict_command(input logic signed [POS_W-1:0] px,
                                                 input logic signed [POS_W-1:0] py,
                                                 input logic signed [YAW_W-1:0] yaw,
                                                 input logic cancel);
    steer_cmd_t r;
    longint dx, dy, vx, vy, z, sx, sy;
    longint dist_v, bearing, err, aerr, lin, ang;
    int i;
    dx = longint'(goal_x) - longint'(px);
    dy = longint'(goal_y) - longint'(py);
    dist_v = 0;
    bearing = 0;
    lin = 0;
    ang = 0;
    r.status = STAT_IDLE;

    // vectoring rotation; on target the bearing stays zero
    if (dx != 0 || dy != 0) begin
      vx = dx;
      vy = dy;
      z = 0;
      if (dx < 0) begin
        vx = -dx;
        vy = -dy;
        z = (dy >= 0) ? PI_Q30L : -PI_Q30L;
      end
      vx = vx * 256;
      vy = vy * 256;
      for (i = 0; i < ROT_STEPS; i++) begin
        sx = vx >>> i;
        sy = vy >>> i;
        if (vy >= 0) begin
          vx = vx + sy;
          vy = vy - sx;
          z = z + atan_lut[i];
        end else begin
          vx = vx - sy;
          vy = vy + sx;
          z = z - atan_lut[i];
        end
      end
      dist_v = (vx * INV_K_Q24 + (64'sd1 <<< 31)) >>> 32;
      if (dist_v > DIST_CAP) dist_v = DIST_CAP;
      bearing = (z + 65536) >>> 17;
    end

    // wrap heading error into (-pi, pi]
    err = bearing - longint'(yaw);
    while (err > PI_Q13L) err = err - 2 * PI_Q13L;
    while (err <= -PI_Q13L) err = err + 2 * PI_Q13L;
    aerr = (err < 0) ? -err : err;

    case (goal_phase)
      PH_ACTIVE: begin
        if (dist_v > longint'(near_tol)) begin
          if (cancel) begin
            goal_phase = PH_CANCELED;
            r.status = STAT_CANCELED;
          end else if (aerr > longint'(align_tol)) begin
            ang = turn_rate(k_turn_move, err);
            r.status = STAT_FIX_YAW;
          end else begin
            lin = (longint'(k_lin) * dist_v + 128) >>> 8;
            if (lin > longint'(speed_cap)) lin = longint'(speed_cap);
            r.status = STAT_GO;
          end
        end else if (aerr > longint'(align_tol)) begin
          ang = turn_rate(k_turn_final, err);
          r.status = STAT_FIX_YAW;
        end else begin
          goal_phase = PH_SUCCEEDED;
          r.status = STAT_SUCCEEDED;
        end
      end
      PH_SUCCEEDED: r.status = STAT_SUCCEEDED;
      PH_CANCELED:  r.status = STAT_CANCELED;
      default:      r.status = STAT_IDLE;
    endcase

    r.speed    = lin[SPEED_W-1:0];
    r.rate     = ang[RATE_W-1:0];
    r.dist_err = dist_v[DIST_W-1:0];
    r.heading  = err[YAW_W-1:0];
    r.wide_err = (aerr > HALF_PI_L);
    return r;
  endfunction

  // Track writes, queue predictions on request accept, compare on result accept
  always @(posedge clk) begin
    if (!rst_n) begin
      goal_x       = '0;
      goal_y       = '0;
      near_tol     = 20'd102;
      align_tol    = 15'd1638;
      k_turn_move  = 10'd128;
      k_turn_final = 10'd179;
      k_lin        = 10'd128;
      speed_cap    = 16'd819;
      goal_phase   = PH_IDLE;
      expected_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_TARGET_X: begin
            goal_x = cfg_wr_data[POS_W-1:0];
            goal_phase = PH_ACTIVE;
          end
          REG_TARGET_Y: begin
            goal_y = cfg_wr_data[POS_W-1:0];
            goal_phase = PH_ACTIVE;
          end
          REG_DIST_TOLERANCE:   near_tol = cfg_wr_data[TOL_D_W-1:0];
          REG_YAW_TOLERANCE:    align_tol = cfg_wr_data[TOL_Y_W-1:0];
          REG_TURN_GAIN_MOVING: k_turn_move = cfg_wr_data[GAIN_W-1:0];
          REG_TURN_GAIN_FINAL:  k_turn_final = cfg_wr_data[GAIN_W-1:0];
          REG_LINEAR_GAIN:      k_lin = cfg_wr_data[GAIN_W-1:0];
          REG_MAX_FWD_SPEED:    speed_cap = cfg_wr_data[SPEED_W-1:0];
          default: ;
        endcase
      end

      if (in_valid && in_ready)
        expected_q.push_back(predict_command(in_current_x, in_current_y, in_current_yaw,
                                             in_cancel_request));

      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unrequested result, status", longint'(out_status), 0);
        end else begin
          head = expected_q.pop_front();
          if (out_fwd_speed !== head.speed)
            report_mismatch("fwd_speed", longint'(out_fwd_speed), longint'(head.speed));
          if (out_angular_rate !== head.rate)
            report_mismatch("angular_rate", longint'(out_angular_rate), longint'(head.rate));
          if (out_status !== head.status)
            report_mismatch("status", longint'(out_status), longint'(head.status));
          if (out_distance_error !== head.dist_err)
            report_mismatch("distance_error", longint'(out_distance_error),
                            longint'(head.dist_err));
          if (out_heading_error !== head.heading)
            report_mismatch("heading_error", longint'(out_heading_error),
                            longint'(head.heading));
          if (out_large_heading_error !== head.wide_err)
            report_mismatch("large_heading_error", longint'(out_large_heading_error),
                            longint'(head.wide_err));
        end
      end
    end
    pend_count = expected_q.size();
  end

endmodule

>>> sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gtp_pkg::*;

  localparam int RANDOM_ITEMS = 750;
  localparam int CALM_TAIL    = 100;
  localparam int WATCH_LIMIT  = 2000;
  localparam int TAIL_WAIT    = 60;
  localparam longint POS_MIN  = -64'sd8388608;
  localparam longint POS_MAX  = 64'sd8388607;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_wr_en = 1'b0;
  logic [IDX_W-1:0]          cfg_index = '0;
  logic [CFG_W-1:0]          cfg_wr_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [POS_W-1:0]   in_current_x = '0;
  logic signed [POS_W-1:0]   in_current_y = '0;
  logic signed [YAW_W-1:0]   in_current_yaw = '0;
  logic                      in_cancel_request = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b1;
  logic [SPEED_W-1:0]        out_fwd_speed;
  logic signed [RATE_W-1:0]  out_angular_rate;
  logic [STATUS_W-1:0]       out_status;
  logic [DIST_W-1:0]         out_distance_error;
  logic signed [YAW_W-1:0]   out_heading_error;
  logic                      out_large_heading_error;

  int mismatches;
  int pending;

  // stimulus-side view of the goal, used to aim the poses
  longint tgt_x = 0, tgt_y = 0, dtol = 102, ytol = 1638;
  int sent = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int stuck_cycles = 0;
  int dir_cx [8] = '{1, 1, 0, -1, -1, -1, 0, 1};
  int dir_cy [8] = '{0, 1, 1, 1, 0, -1, -1, -1};

  go_to_point_steering_controller_core uut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_wr_en               (cfg_wr_en),
    .cfg_index               (cfg_index),
    .cfg_wr_data             (cfg_wr_data),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_current_x            (in_current_x),
    .in_current_y            (in_current_y),
    .in_current_yaw          (in_current_yaw),
    .in_cancel_request       (in_cancel_request),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_fwd_speed           (out_fwd_speed),
    .out_angular_rate        (out_angular_rate),
    .out_status              (out_status),
    .out_distance_error      (out_distance_error),
    .out_heading_error       (out_heading_error),
    .out_large_heading_error (out_large_heading_error)
  );

  steer_check checker_i (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_wr_en               (cfg_wr_en),
    .cfg_index               (cfg_index),
    .cfg_wr_data             (cfg_wr_data),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_current_x            (in_current_x),
    .in_current_y            (in_current_y),
    .in_current_yaw          (in_current_yaw),
    .in_cancel_request       (in_cancel_request),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_fwd_speed           (out_fwd_speed),
    .out_angular_rate        (out_angular_rate),
    .out_status              (out_status),
    .out_distance_error      (out_distance_error),
    .out_heading_error       (out_heading_error),
    .out_large_heading_error (out_large_heading_error),
    .mismatches              (mismatches),
    .pending                 (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stall the result side in random bursts
  always @(posedge clk) begin
    if (hold_left > 1) begin
      hold_left <= hold_left - 1;
    end else if (hold_left == 1) begin
      hold_left <= 0;
      out_ready <= 1'b1;
    end else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
      hold_left <= int'($urandom_range(1, 14));
      out_ready <= 1'b0;
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= WATCH_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int pick_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 10;
      2: return 30;
      default: return 60;
    endcase
  endfunction

  function automatic longint pick_range(input longint lo, input longint hi);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return lo + longint'($urandom_range(0, 32'(hi - lo)));
  endfunction

  function automatic longint clamp_pos(input longint v);
    if (v < POS_MIN) return POS_MIN;
    if (v > POS_MAX) return POS_MAX;
    return v;
  endfunction

  // Present one request, after an optional gap, and hold it until taken
  task automatic send_tick(input longint x, input longint y, input longint yaw,
                           input int cancel);
    int gap;
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      gap = int'($urandom_range(1, 14));
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_current_x      <= POS_W'(x);
    in_current_y      <= POS_W'(y);
    in_current_yaw    <= YAW_W'(yaw);
    in_cancel_request <= (cancel != 0);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  // Drop valid and hold until every result is back
  task automatic await_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic cfg_put(input reg_idx_t idx, input longint v);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= CFG_W'(v);
    case (idx)
      REG_TARGET_X:       tgt_x = v;
      REG_TARGET_Y:       tgt_y = v;
      REG_DIST_TOLERANCE: dtol = v;
      REG_YAW_TOLERANCE:  ytol = v;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Write a random subset of registers; a target write opens a new goal
  task automatic new_setting();
    longint v;
    int r;
    if ($urandom_range(0, 99) < 85) begin
      v = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1) != 0) ? POS_MIN : POS_MAX)
                                      : longint'($urandom_range(0, 8388607)) - 4194304;
      cfg_put(REG_TARGET_X, v);
    end
    if ($urandom_range(0, 99) < 85) begin
      v = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1) != 0) ? POS_MIN : POS_MAX)
                                      : longint'($urandom_range(0, 8388607)) - 4194304;
      cfg_put(REG_TARGET_Y, v);
    end
    if ($urandom_range(0, 1) != 0) begin
      r = int'($urandom_range(0, 9));
      v = (r == 0) ? 0 : (r == 1) ? 1048575 : (r == 2) ? longint'($urandom_range(0, 1048575))
                                                       : longint'($urandom_range(0, 3000));
      cfg_put(REG_DIST_TOLERANCE, v);
    end
    if ($urandom_range(0, 1) != 0) begin
      r = int'($urandom_range(0, 9));
      v = (r == 0) ? 0 : (r == 1) ? 32767 : longint'($urandom_range(200, 4000));
      cfg_put(REG_YAW_TOLERANCE, v);
    end
    if ($urandom_range(0, 1) != 0) cfg_put(REG_TURN_GAIN_MOVING, pick_range(0, 1023));
    if ($urandom_range(0, 1) != 0) cfg_put(REG_TURN_GAIN_FINAL, pick_range(0, 1023));
    if ($urandom_range(0, 1) != 0) cfg_put(REG_LINEAR_GAIN, pick_range(0, 1023));
    if ($urandom_range(0, 1) != 0) cfg_put(REG_MAX_FWD_SPEED, pick_range(0, 65535));
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly approach the target from one of eight directions, closing in over the run
  task automatic run_goal(input int n);
    int k, kind, dir, r, cancel;
    longint m, dx, dy, yaw;
    for (k = 0; k < n; k++) begin
      kind = int'($urandom_range(0, 99));
      cancel = ($urandom_range(0, 99) < 6) ? 1 : 0;
      if (kind < 15) begin
        send_tick(longint'($urandom), longint'($urandom), longint'($urandom),
                  int'($urandom_range(0, 1)));
      end else begin
        dir = int'($urandom_range(0, 7));
        if (kind < 25)
          m = 0;
        else if (int'($urandom_range(0, 32'(n))) < k)
          m = longint'($urandom_range(0, 32'(dtol)));
        else
          m = dtol + 1 + longint'($urandom_range(0, 1 << 20));
        if (dir % 2 == 1) m = m * 181 / 256;
        dx = m * dir_cx[dir];
        dy = m * dir_cy[dir];
        yaw = longint'((dir > 4) ? dir - 8 : dir) * 6434;
        r = int'($urandom_range(0, 9));
        if (r < 5)
          yaw = yaw + longint'($urandom_range(0, 32'(ytol))) - ytol / 2;
        else if (r < 8)
          yaw = yaw + (($urandom_range(0, 1) != 0) ? 1 : -1) *
                (ytol + 1 + longint'($urandom_range(0, 8000)));
        else
          yaw = longint'($urandom);
        if (r < 8 && yaw > 25736) yaw = yaw - 51472;
        if (r < 8 && yaw < -25736) yaw = yaw + 51472;
        send_tick(clamp_pos(tgt_x - dx), clamp_pos(tgt_y - dy), yaw, cancel);
      end
    end
  endtask

  initial begin
    int random_start;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // no goal yet: idle status, cancel ignored
    send_tick(0, 0, 0, 0);
    send_tick(POS_MIN, POS_MAX, -32768, 1);

    // goal in the far corner with top moving and linear gains and speed ceiling
    await_idle();
    cfg_put(REG_TARGET_X, POS_MAX);
    cfg_put(REG_TARGET_Y, POS_MAX);
    cfg_put(REG_TURN_GAIN_MOVING, 1023);
    cfg_put(REG_LINEAR_GAIN, 1023);
    cfg_put(REG_MAX_FWD_SPEED, 65535);
    cfg_wr_en <= 1'b0;
    send_tick(POS_MIN, POS_MIN, 32767, 0);
    send_tick(POS_MAX - 1000000, POS_MAX, 0, 0);
    send_tick(POS_MAX - 1000000, POS_MAX, 2000, 0);
    send_tick(POS_MAX - 50, POS_MAX, 20000, 1);
    send_tick(POS_MAX, POS_MAX, 100, 0);
    send_tick(0, 0, 0, 1);

    // zero tolerances: heading error near pi, then cancel while far
    await_idle();
    cfg_put(REG_TARGET_X, POS_MIN);
    cfg_put(REG_DIST_TOLERANCE, 0);
    cfg_put(REG_YAW_TOLERANCE, 0);
    cfg_put(REG_TURN_GAIN_FINAL, 1023);
    cfg_put(REG_MAX_FWD_SPEED, 0);
    cfg_wr_en <= 1'b0;
    send_tick(POS_MIN + 5, POS_MAX, 0, 0);
    send_tick(POS_MIN, POS_MAX - 7, -12868, 0);
    send_tick(POS_MIN + 300, POS_MAX, 25736, 0);
    send_tick(0, 0, 0, 1);
    send_tick(POS_MIN, POS_MAX, 0, 1);

    // huge tolerances and zero gains: succeed at once
    await_idle();
    cfg_put(REG_TARGET_Y, POS_MIN);
    cfg_put(REG_DIST_TOLERANCE, 1048575);
    cfg_put(REG_YAW_TOLERANCE, 32767);
    cfg_put(REG_TURN_GAIN_MOVING, 0);
    cfg_put(REG_TURN_GAIN_FINAL, 0);
    cfg_put(REG_LINEAR_GAIN, 0);
    cfg_wr_en <= 1'b0;
    send_tick(POS_MIN + 2000, POS_MIN + 3000, 12000, 0);

    // drive straight with zero linear gain
    await_idle();
    cfg_put(REG_TARGET_X, 0);
    cfg_put(REG_DIST_TOLERANCE, 0);
    cfg_put(REG_YAW_TOLERANCE, 1638);
    cfg_wr_en <= 1'b0;
    send_tick(-4000, POS_MIN, 0, 0);

    // random goals; the tail runs with no idling on either side
    random_start = sent;
    while (sent - random_start < RANDOM_ITEMS) begin
      await_idle();
      if (sent - random_start >= RANDOM_ITEMS - CALM_TAIL) begin
        gap_pct = 0;
        stall_pct = 0;
      end else begin
        gap_pct = pick_pct();
        stall_pct = pick_pct();
      end
      new_setting();
      run_goal(int'($urandom_range(5, 30)));
    end

    await_idle();
    repeat (TAIL_WAIT) @(posedge clk);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> go_to_point_steering_controller_core.f
rtl/gtp_pkg.sv
rtl/go_to_point_steering_controller_core.sv
sim/steer_check.sv
sim/tb.sv
